/* rtl/core/dkt_pkg.sv */
// ----------------------------------------------------------------------------
// dkt_pkg
// Shared sizes, codes and control bundles for the dense key table.
// ----------------------------------------------------------------------------
package dkt_pkg;

  localparam int CAPACITY  = 64;
  localparam int KEY_LIMIT = 1024;

  localparam int KEY_W  = $clog2(KEY_LIMIT);
  localparam int SLOT_W = $clog2(CAPACITY);
  localparam int OCC_W  = $clog2(CAPACITY + 1);
  localparam int IDX_W  = 1 + SLOT_W;
  localparam int EVT_W  = 16;
  localparam int POS_W  = 6;
  localparam int OP_W   = 2;
  localparam int STAT_W = 2;

  localparam int IN_W     = KEY_W + EVT_W + POS_W;
  localparam int S_DATA_W = ((IN_W + 7) / 8) * 8;
  localparam int OUT_W    = 1 + KEY_W + EVT_W + OCC_W + STAT_W;
  localparam int M_DATA_W = ((OUT_W + 7) / 8) * 8;

  typedef enum logic [OP_W-1:0] {
    OP_ADD      = 2'd0,
    OP_REMOVE   = 2'd1,
    OP_CONTAINS = 2'd2,
    OP_READ     = 2'd3
  } op_t;

  typedef enum logic [STAT_W-1:0] {
    ST_OK      = 2'd0,
    ST_POS_OOR = 2'd1,
    ST_FULL    = 2'd2,
    ST_KEY_OOR = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_LOOKUP,
    S_UPDATE,
    S_UNLINK,
    S_RESULT
  } state_t;

  typedef struct packed {
    logic clear;
    logic load;
    logic res_load;
    logic append;
    logic move;
    logic fetch;
    logic merge;
    logic unlink;
    logic out_load;
  } ctrl_cmd_t;

  typedef struct packed {
    op_t  op;
    logic key_oor;
    logic present;
    logic full;
    logic slot_last;
    logic clear_last;
    logic out_free;
  } ctrl_stat_t;

endpackage

/* rtl/core/dense_key_table_swap_remove_top.sv */
// ----------------------------------------------------------------------------
// dense_key_table_swap_remove_top
// Packed key/event-mask table with key index and swap-remove.
// ----------------------------------------------------------------------------
// input words on s_axis: tuser carries the command (add/update, remove,
// contains, read by position), tdata the key, event mask and position.
// every input word gives exactly one output word on m_axis with hit, slot
// key, slot events, occupancy after the command and a status code.
// path, accept to output valid: a lookup state, then a result state that
// loads the output register once it is free; an update of a present key
// adds an update state (read-modify-write of the event memory), a remove
// of a present key an unlink state (second write on the key index memory).
// one command is in flight at a time: a new word is taken only after the
// last result has entered the output register; the index memory's single
// write port and registered reads set this sequence of states. after reset
// the key index memory is swept clean, one entry a cycle, s_axis_tready low.
// a stalled m_axis holds the output word; the next input word is still
// taken, and its result waits until the output register frees.
// ----------------------------------------------------------------------------
module dense_key_table_swap_remove_top (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  // key, event_mask, position, zero fill
  input  logic [dkt_pkg::S_DATA_W-1:0]  s_axis_tdata,
  // command
  input  logic [dkt_pkg::OP_W-1:0]      s_axis_tuser,
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // hit, slot_key, slot_events, occupancy, status, zero fill
  output logic [dkt_pkg::M_DATA_W-1:0]  m_axis_tdata
);

  dkt_pkg::ctrl_cmd_t  cmd;
  dkt_pkg::ctrl_stat_t stat;

  dkt_ctrl u_ctrl (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .stat          (stat),
    .cmd           (cmd)
  );

  dkt_datapath u_datapath (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .stat          (stat),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

endmodule

/* rtl/core/dkt_ctrl.sv */
// ----------------------------------------------------------------------------
// dkt_ctrl
// Command sequencer: index clear sweep, lookup, update, unlink, result.
// ----------------------------------------------------------------------------
module dkt_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  input  dkt_pkg::ctrl_stat_t  stat,
  output dkt_pkg::ctrl_cmd_t   cmd
);

  dkt_pkg::state_t state;
  dkt_pkg::state_t state_next;
  logic            live;

  assign live = !stat.key_oor;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= dkt_pkg::S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      dkt_pkg::S_CLEAR: begin
        if (stat.clear_last) state_next = dkt_pkg::S_IDLE;
      end
      dkt_pkg::S_IDLE: begin
        if (s_axis_tvalid) state_next = dkt_pkg::S_LOOKUP;
      end
      dkt_pkg::S_LOOKUP: begin
        if (stat.op == dkt_pkg::OP_ADD && live && stat.present) begin
          state_next = dkt_pkg::S_UPDATE;
        end else if (stat.op == dkt_pkg::OP_REMOVE && live && stat.present) begin
          state_next = dkt_pkg::S_UNLINK;
        end else begin
          state_next = dkt_pkg::S_RESULT;
        end
      end
      dkt_pkg::S_UPDATE: state_next = dkt_pkg::S_RESULT;
      dkt_pkg::S_UNLINK: state_next = dkt_pkg::S_RESULT;
      dkt_pkg::S_RESULT: begin
        if (stat.out_free) state_next = dkt_pkg::S_IDLE;
      end
      default: state_next = dkt_pkg::S_CLEAR;
    endcase
  end

  always_comb begin
    cmd           = '0;
    s_axis_tready = 1'b0;
    unique case (state)
      dkt_pkg::S_CLEAR: cmd.clear = 1'b1;
      dkt_pkg::S_IDLE: begin
        s_axis_tready = 1'b1;
        cmd.load      = s_axis_tvalid;
      end
      dkt_pkg::S_LOOKUP: begin
        cmd.res_load = 1'b1;
        cmd.append   = stat.op == dkt_pkg::OP_ADD && live && !stat.present && !stat.full;
        cmd.fetch    = stat.op == dkt_pkg::OP_ADD && live && stat.present;
        cmd.move     = stat.op == dkt_pkg::OP_REMOVE && live && stat.present &&
                       !stat.slot_last;
      end
      dkt_pkg::S_UPDATE: cmd.merge  = 1'b1;
      dkt_pkg::S_UNLINK: cmd.unlink = 1'b1;
      dkt_pkg::S_RESULT: cmd.out_load = stat.out_free;
      default: cmd = '0;
    endcase
  end

endmodule

/* rtl/core/dkt_datapath.sv */
// ----------------------------------------------------------------------------
// dkt_datapath
// Slot and index memories, entry count, result and output registers.
// ----------------------------------------------------------------------------
module dkt_datapath (
  input  logic                          clk,
  input  logic                          rst,
  input  dkt_pkg::ctrl_cmd_t            cmd,
  output dkt_pkg::ctrl_stat_t           stat,
  input  logic [dkt_pkg::S_DATA_W-1:0]  s_axis_tdata,
  input  logic [dkt_pkg::OP_W-1:0]      s_axis_tuser,
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  output logic [dkt_pkg::M_DATA_W-1:0]  m_axis_tdata
);

  logic [dkt_pkg::IDX_W-1:0] idx_mem [dkt_pkg::KEY_LIMIT];
  logic [dkt_pkg::KEY_W-1:0] key_mem [dkt_pkg::CAPACITY];
  logic [dkt_pkg::EVT_W-1:0] evt_mem [dkt_pkg::CAPACITY];

  dkt_pkg::op_t              op_r;
  logic [dkt_pkg::KEY_W-1:0] key_r;
  logic [dkt_pkg::EVT_W-1:0] evt_r;
  logic [dkt_pkg::POS_W-1:0] pos_r;
  logic [dkt_pkg::OCC_W-1:0] count;
  logic [dkt_pkg::KEY_W-1:0] clr_cnt;

  logic [dkt_pkg::IDX_W-1:0] idx_rd;
  logic [dkt_pkg::KEY_W-1:0] key_rd;
  logic [dkt_pkg::EVT_W-1:0] evt_rd;

  logic                      res_hit;
  logic [dkt_pkg::KEY_W-1:0] res_skey;
  logic [dkt_pkg::EVT_W-1:0] res_sevt;
  dkt_pkg::status_t          res_status;

  logic                      res_hit_next;
  logic [dkt_pkg::KEY_W-1:0] res_skey_next;
  logic [dkt_pkg::EVT_W-1:0] res_sevt_next;
  dkt_pkg::status_t          res_status_next;

  dkt_pkg::op_t               in_op;
  logic [dkt_pkg::KEY_W-1:0]  in_key;
  logic [dkt_pkg::EVT_W-1:0]  in_evt;
  logic [dkt_pkg::POS_W-1:0]  in_pos;

  logic [dkt_pkg::OCC_W-1:0]  last_full;
  logic [dkt_pkg::SLOT_W-1:0] last;
  logic [dkt_pkg::SLOT_W-1:0] idx_slot;
  logic                       idx_valid;
  logic                       key_oor;
  logic                       pos_ok;

  logic                       slot_re;
  logic [dkt_pkg::SLOT_W-1:0] slot_ra;
  logic                       key_we;
  logic [dkt_pkg::SLOT_W-1:0] key_wa;
  logic [dkt_pkg::KEY_W-1:0]  key_wd;
  logic                       evt_we;
  logic [dkt_pkg::SLOT_W-1:0] evt_wa;
  logic [dkt_pkg::EVT_W-1:0]  evt_wd;
  logic                       idx_we;
  logic [dkt_pkg::KEY_W-1:0]  idx_wa;
  logic [dkt_pkg::IDX_W-1:0]  idx_wd;

  // word unpack
  assign in_op  = dkt_pkg::op_t'(s_axis_tuser);
  assign in_key = s_axis_tdata[dkt_pkg::KEY_W-1:0];
  assign in_evt = s_axis_tdata[dkt_pkg::KEY_W +: dkt_pkg::EVT_W];
  assign in_pos = s_axis_tdata[dkt_pkg::KEY_W+dkt_pkg::EVT_W +: dkt_pkg::POS_W];

  assign last_full = count - dkt_pkg::OCC_W'(1);
  assign last      = last_full[dkt_pkg::SLOT_W-1:0];
  assign idx_valid = idx_rd[dkt_pkg::IDX_W-1];
  assign idx_slot  = idx_rd[dkt_pkg::SLOT_W-1:0];
  assign key_oor   = {1'b0, key_r} >= (dkt_pkg::KEY_W+1)'(dkt_pkg::KEY_LIMIT);
  assign pos_ok    = dkt_pkg::OCC_W'(pos_r) < count;

  assign stat.op         = op_r;
  assign stat.key_oor    = key_oor;
  assign stat.present    = idx_valid;
  assign stat.full       = count == dkt_pkg::OCC_W'(dkt_pkg::CAPACITY);
  assign stat.slot_last  = idx_slot == last;
  assign stat.clear_last = clr_cnt == dkt_pkg::KEY_W'(dkt_pkg::KEY_LIMIT - 1);
  assign stat.out_free   = !m_axis_tvalid || m_axis_tready;

  // read port: last entry or position on load, own slot on fetch
  always_comb begin
    slot_re = cmd.load || cmd.fetch;
    if (cmd.load) begin
      slot_ra = (in_op == dkt_pkg::OP_READ) ? dkt_pkg::SLOT_W'(in_pos) : last;
    end else begin
      slot_ra = idx_slot;
    end
  end

  always_comb begin
    key_we = cmd.append || cmd.move;
    key_wa = cmd.append ? count[dkt_pkg::SLOT_W-1:0] : idx_slot;
    key_wd = cmd.append ? key_r : key_rd;

    evt_we = cmd.append || cmd.move || cmd.merge;
    evt_wa = cmd.append ? count[dkt_pkg::SLOT_W-1:0] : idx_slot;
    if (cmd.append) begin
      evt_wd = evt_r;
    end else if (cmd.merge) begin
      evt_wd = evt_rd | evt_r;
    end else begin
      evt_wd = evt_rd;
    end

    idx_we = cmd.clear || cmd.append || cmd.move || cmd.unlink;
    idx_wa = key_r;
    idx_wd = '0;
    if (cmd.clear) begin
      idx_wa = clr_cnt;
    end else if (cmd.append) begin
      idx_wd = {1'b1, count[dkt_pkg::SLOT_W-1:0]};
    end else if (cmd.move) begin
      idx_wa = key_rd;
      idx_wd = {1'b1, idx_slot};
    end
  end

  always_ff @(posedge clk) begin
    if (idx_we) idx_mem[idx_wa] <= idx_wd;
    if (cmd.load) idx_rd <= idx_mem[in_key];
  end

  always_ff @(posedge clk) begin
    if (key_we) key_mem[key_wa] <= key_wd;
    if (slot_re) key_rd <= key_mem[slot_ra];
  end

  always_ff @(posedge clk) begin
    if (evt_we) evt_mem[evt_wa] <= evt_wd;
    if (slot_re) evt_rd <= evt_mem[slot_ra];
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r  <= in_op;
      key_r <= in_key;
      evt_r <= in_evt;
      pos_r <= in_pos;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count   <= '0;
      clr_cnt <= '0;
    end else begin
      if (cmd.clear) clr_cnt <= clr_cnt + dkt_pkg::KEY_W'(1);
      if (cmd.append) begin
        count <= count + dkt_pkg::OCC_W'(1);
      end else if (cmd.unlink) begin
        count <= last_full;
      end
    end
  end

  always_comb begin
    res_hit_next    = 1'b0;
    res_skey_next   = '0;
    res_sevt_next   = '0;
    res_status_next = dkt_pkg::ST_OK;
    if (op_r == dkt_pkg::OP_READ) begin
      if (pos_ok) begin
        res_skey_next = key_rd;
        res_sevt_next = evt_rd;
      end else begin
        res_status_next = dkt_pkg::ST_POS_OOR;
      end
    end else if (key_oor) begin
      res_status_next = dkt_pkg::ST_KEY_OOR;
    end else if (op_r == dkt_pkg::OP_ADD && !idx_valid && stat.full) begin
      res_status_next = dkt_pkg::ST_FULL;
    end else begin
      res_hit_next = idx_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.res_load) begin
      res_hit    <= res_hit_next;
      res_skey   <= res_skey_next;
      res_sevt   <= res_sevt_next;
      res_status <= res_status_next;
    end
  end

  // output word register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (cmd.out_load) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      m_axis_tdata <= {{(dkt_pkg::M_DATA_W-dkt_pkg::OUT_W){1'b0}},
                       res_status, count, res_sevt, res_skey, res_hit};
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= dkt_pkg::OCC_W'(dkt_pkg::CAPACITY))
    else $error("entry count above capacity");

  a_append_room: assert property (@(posedge clk) disable iff (rst)
    cmd.append |-> count < dkt_pkg::OCC_W'(dkt_pkg::CAPACITY))
    else $error("append into full table");

  a_out_free: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> (!m_axis_tvalid || m_axis_tready))
    else $error("result overwrites pending word");

  a_unlink_dec: assert property (@(posedge clk) disable iff (rst)
    cmd.unlink |=> count == $past(last_full))
    else $error("remove did not shrink count");

  a_unlink_present: assert property (@(posedge clk) disable iff (rst)
    cmd.unlink |-> (idx_valid && count != '0))
    else $error("unlink of absent key");

endmodule
